@@ src/fbpa_pkg.sv @@
// Shared types, constants and codes of the fixed block pool allocator.
package fbpa_pkg;

    localparam int MaxSlots = 1024;
    localparam int Align = 16;
    localparam int AlignLog = $clog2(Align);
    localparam int SlotW = $clog2(MaxSlots);
    localparam int CountW = SlotW + 1;

    localparam logic [1:0] REQ_RESERVE = 2'd0;
    localparam logic [1:0] REQ_RELEASE = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    localparam logic [2:0] ST_DONE = 3'd0;
    localparam logic [2:0] ST_BAD_SIZE = 3'd1;
    localparam logic [2:0] ST_EMPTY = 3'd2;
    localparam logic [2:0] ST_BAD_ADDR = 3'd3;
    localparam logic [2:0] ST_ALREADY_FREE = 3'd4;

    localparam logic [1:0] CFG_POOL_BASE = 2'd0;
    localparam logic [1:0] CFG_POOL_BYTES = 2'd1;
    localparam logic [1:0] CFG_SLOT_STRIDE = 2'd2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] num_elems;
        logic [31:0] elem_bytes;
        logic [31:0] addr;
    } t_req;

    typedef struct packed {
        logic        ok;
        logic [2:0]  status;
        logic [31:0] data_addr;
        logic [10:0] free_count;
    } t_rsp;

    typedef struct packed {
        logic [1:0]  index;
        logic [31:0] data;
    } t_cfg;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture the request, start the checks
        logic div_start;  // start the slot divider
        logic div_step;   // one quotient bit
        logic mul_step;   // one product step
        logic clr_start;  // begin the rebuild sweep
        logic clr_step;   // one slot of the sweep
        logic commit;     // finish the request and fill the result
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_done;
        logic mul_done;
        logic clr_done;
    } t_sts;

endpackage

@@ src/fbpa_if.sv @@
// Valid/ready channel interfaces for requests, results and configuration.
interface fbpa_req_if;
    import fbpa_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface fbpa_rsp_if;
    import fbpa_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface fbpa_cfg_if;
    import fbpa_pkg::*;
    logic valid;
    logic ready;
    t_cfg data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ src/fixed_block_pool_allocator.sv @@
// Top level of the fixed block pool allocator.
//
// Requests arrive on i_req (valid/ready, one transaction per request) and each
// produces exactly one result on o_rsp. Configuration registers (pool base,
// pool bytes, slot stride) are written over i_cfg, which is always ready. The user
// must see that they are changed only while no request is in work; the block does not enforce it.
//
// Work per request: a reserve runs a 32-step shift/add multiplier, a release
// a 21-step restoring divider for the slot index, a clear the same divider for
// the slot count plus one sweep step per slot (up to 1024) for the rebuild,
// and an unknown request goes straight to its result. One request is in work
// at a time, and the next one is taken only after the result is.
//
// After reset the pool holds no slots and every well-formed reserve reports
// an empty pool until a clear is done. The result register holds its value
// while the receiver stalls; no new request is taken during the stall.
module fixed_block_pool_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fbpa_req_if.sink    i_req,
    fbpa_rsp_if.source  o_rsp,
    fbpa_cfg_if.sink    i_cfg
);
    import fbpa_pkg::*;

    logic [31:0] r_pool_base;
    logic [20:0] r_pool_bytes;
    logic [16:0] r_slot_stride;
    logic        r_rsp_valid;
    t_cmd        w_cmd;
    t_sts        w_sts;
    t_rsp        w_rsp;

    assign i_cfg.ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_base <= '0;
            r_pool_bytes <= '0;
            r_slot_stride <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.data.index)
                CFG_POOL_BASE: r_pool_base <= i_cfg.data.data;
                CFG_POOL_BYTES: r_pool_bytes <= i_cfg.data.data[20:0];
                CFG_SLOT_STRIDE: r_slot_stride <= i_cfg.data.data[16:0];
                default: ;
            endcase
        end
    end

    fbpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_type  (i_req.data.req_type),
        .i_rsp_busy  (r_rsp_valid),
        .i_sts       (w_sts),
        .o_req_ready (i_req.ready),
        .o_cmd       (w_cmd)
    );

    fbpa_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_req         (i_req.data),
        .i_pool_base   (r_pool_base),
        .i_pool_bytes  (r_pool_bytes),
        .i_slot_stride (r_slot_stride),
        .o_sts         (w_sts),
        .o_rsp         (w_rsp)
    );

    // Result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (w_cmd.commit) begin
            r_rsp_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    assign o_rsp.valid = r_rsp_valid;
    assign o_rsp.data = w_rsp;

    // A request is never taken while a result is waiting.
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rsp_valid |-> !i_req.ready)
        else $error("request taken while result pending");

    // A successful result always reports done.
    a_ok_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.data.ok |-> o_rsp.data.status == ST_DONE)
        else $error("ok without done status");

    // A commit only follows an accepted request, never two in a row.
    a_single_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |=> !w_cmd.commit)
        else $error("double commit");

endmodule

@@ src/fbpa_ctrl.sv @@
// Controller state machine of the fixed block pool allocator.
module fbpa_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    input  logic [1:0]      i_req_type,
    input  logic            i_rsp_busy,
    input  fbpa_pkg::t_sts  i_sts,
    output logic            o_req_ready,
    output fbpa_pkg::t_cmd  o_cmd
);
    import fbpa_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV = 3'd1;
    localparam logic [2:0] S_MUL = 3'd2;
    localparam logic [2:0] S_CLR = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_req_ready = (r_state == S_IDLE) && !i_rsp_busy;

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid && o_req_ready) begin
                    o_cmd.load = 1'b1;
                    case (i_req_type)
                        REQ_RESERVE: n_state = S_MUL;
                        REQ_RELEASE: begin
                            o_cmd.div_start = 1'b1;
                            n_state = S_DIV;
                        end
                        REQ_CLEAR: begin
                            o_cmd.div_start = 1'b1;
                            n_state = S_DIV;
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    if (i_sts.clr_done) begin
                        n_state = S_DONE;
                    end else begin
                        o_cmd.clr_start = 1'b1;
                        n_state = S_CLR;
                    end
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_MUL: begin
                if (i_sts.mul_done) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.mul_step = 1'b1;
                end
            end
            S_CLR: begin
                if (i_sts.clr_done) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.clr_step = 1'b1;
                end
            end
            S_DONE: begin
                o_cmd.commit = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ src/fbpa_dp.sv @@
// Datapath of the fixed block pool allocator: divider, multiplier, free list.
module fbpa_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  fbpa_pkg::t_cmd  i_cmd,
    input  fbpa_pkg::t_req  i_req,
    input  logic [31:0]     i_pool_base,
    input  logic [20:0]     i_pool_bytes,
    input  logic [16:0]     i_slot_stride,
    output fbpa_pkg::t_sts  o_sts,
    output fbpa_pkg::t_rsp  o_rsp
);
    import fbpa_pkg::*;

    localparam int QuoW = 21;
    localparam int QcntW = $clog2(QuoW + 1);
    localparam int SizeW = 18;

    // Free list state.
    logic [SlotW-1:0]  r_link [MaxSlots];
    logic              r_free [MaxSlots];
    logic [CountW-1:0] r_head;
    logic [CountW-1:0] r_free_total;
    logic [CountW-1:0] r_slot_total;
    logic [SlotW-1:0]  r_link_rd;
    logic              r_free_rd;

    // Captured request and check results.
    t_req              r_req;
    logic              r_is_clear;
    logic              r_addr_bad;
    logic [20:0]       r_delta;

    // Restoring divider: quotient and remainder of a 21-bit dividend.
    logic [SizeW-1:0]  r_size;
    logic [QuoW-1:0]   r_quo;
    logic [SizeW:0]    r_rem;
    logic [QcntW-1:0]  r_qcnt;
    logic [SizeW:0]    w_rem_sh;
    logic              w_rem_ge;

    // Shift and add multiplier for num_elems * elem_bytes.
    logic [63:0]       r_prod;
    logic [63:0]       r_mcand;
    logic [31:0]       r_mplier;
    logic [5:0]        r_mcnt;

    // Rebuild sweep.
    logic [CountW-1:0] r_clr_idx;
    logic [CountW-1:0] r_clr_n;

    logic [32:0]       w_addr_hdr;
    logic [33:0]       w_delta;
    logic [67:0]       w_pay_prod;
    logic [63:0]       w_rounded;
    logic              w_size_zero;
    logic              w_rsv_ok;
    logic [SlotW-1:0]  w_rel_idx;
    logic              w_rel_ok;
    logic              w_rel_go;

    assign w_rem_sh = {r_rem[SizeW-1:0], r_delta[QuoW-1]};
    assign w_rem_ge = w_rem_sh >= {1'b0, r_size};

    assign o_sts.div_done = (r_qcnt == QcntW'(QuoW));
    assign o_sts.mul_done = (r_mcnt == 6'd32);
    assign o_sts.clr_done = r_is_clear ? (r_clr_idx == r_clr_n) && (r_clr_n != '1) : 1'b1;

    // Address checks made on capture.
    assign w_addr_hdr = {1'b0, i_req.addr} - 33'(Align);
    assign w_delta = {1'b0, w_addr_hdr} - {2'b0, i_pool_base};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
            r_is_clear <= (i_req.req_type == REQ_CLEAR);
            r_size <= SizeW'(i_slot_stride) + SizeW'(Align);
            r_mcand <= {32'b0, i_req.elem_bytes};
            r_mplier <= i_req.num_elems;
            r_prod <= '0;
            r_mcnt <= '0;
            if (i_req.req_type == REQ_CLEAR) begin
                r_addr_bad <= 1'b0;
                r_delta <= (i_slot_stride == '0) ? '0 : i_pool_bytes;
            end else begin
                r_addr_bad <= (i_req.addr < 32'(Align)) || w_delta[33]
                    || (w_delta[32:0] >= {12'b0, i_pool_bytes});
                r_delta <= w_delta[20:0];
            end
        end
        if (i_cmd.div_start) begin
            r_qcnt <= '0;
            r_rem <= '0;
            r_quo <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= w_rem_ge ? (w_rem_sh - {1'b0, r_size}) : w_rem_sh;
            r_quo <= {r_quo[QuoW-2:0], w_rem_ge};
            r_delta <= {r_delta[QuoW-2:0], 1'b0};
            r_qcnt <= r_qcnt + 1'b1;
        end
        if (i_cmd.mul_step) begin
            if (r_mplier[0]) begin
                r_prod <= r_prod + r_mcand;
            end
            r_mcand <= {r_mcand[62:0], 1'b0};
            r_mplier <= {1'b0, r_mplier[31:1]};
            r_mcnt <= r_mcnt + 1'b1;
        end
    end

    // Release index and checks after the division.
    assign w_rel_idx = r_quo[SlotW-1:0];
    assign w_rel_ok = !r_addr_bad && (r_rem == '0)
        && ({{(QuoW-CountW){1'b0}}, r_slot_total} > r_quo);
    assign w_rel_go = w_rel_ok && !r_free_rd;

    assign w_size_zero = (r_req.num_elems == '0) || (r_req.elem_bytes == '0);
    assign w_rounded = (r_prod + 64'(Align - 1)) & ~64'(Align - 1);
    assign w_pay_prod = {36'b0, r_head[SlotW-1:0]} * {50'b0, r_size};
    assign w_rsv_ok = !w_size_zero && (r_free_total != '0) && !r_head[SlotW]
        && !(w_rounded > {47'b0, i_slot_stride});

    // Link memory and free marks, one write and registered reads per cycle.
    // Marks at or above the slot count are never read, so the sweep alone
    // sets up every mark that matters.
    always_ff @(posedge i_clk) begin
        r_link_rd <= r_link[r_head[SlotW-1:0]];
        r_free_rd <= r_free[w_rel_idx];
        if (i_cmd.clr_step) begin
            r_link[r_clr_idx[SlotW-1:0]] <= (r_clr_idx == '0) ? SlotW'(0)
                : r_clr_idx[SlotW-1:0] - 1'b1;
            r_free[r_clr_idx[SlotW-1:0]] <= 1'b1;
        end else if (i_cmd.commit && r_req.req_type == REQ_RELEASE && w_rel_go) begin
            r_link[w_rel_idx] <= r_head[SlotW-1:0];
            r_free[w_rel_idx] <= 1'b1;
        end else if (i_cmd.commit && r_req.req_type == REQ_RESERVE && w_rsv_ok) begin
            r_free[r_head[SlotW-1:0]] <= 1'b0;
        end
    end

    // Count and free-list head registers; result assembly.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= CountW'(MaxSlots);
            r_free_total <= '0;
            r_slot_total <= '0;
            r_clr_idx <= '0;
            r_clr_n <= '1;
        end else begin
            if (i_cmd.clr_start) begin
                r_clr_idx <= '0;
                r_clr_n <= (r_quo > QuoW'(MaxSlots)) ? CountW'(MaxSlots)
                    : r_quo[CountW-1:0];
            end
            if (i_cmd.clr_step) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            if (i_cmd.commit) begin
                o_rsp.ok <= 1'b0;
                o_rsp.status <= ST_BAD_ADDR;
                o_rsp.data_addr <= '0;
                o_rsp.free_count <= r_free_total;
                case (r_req.req_type)
                    REQ_RESERVE: begin
                        if (w_size_zero) begin
                            o_rsp.status <= ST_BAD_SIZE;
                        end else if (r_free_total == '0 || r_head[SlotW]) begin
                            o_rsp.status <= ST_EMPTY;
                        end else if (w_rounded > {47'b0, i_slot_stride}) begin
                            o_rsp.status <= ST_BAD_SIZE;
                        end else begin
                            o_rsp.ok <= 1'b1;
                            o_rsp.status <= ST_DONE;
                            o_rsp.data_addr <= i_pool_base + w_pay_prod[31:0]
                                + 32'(Align);
                            o_rsp.free_count <= r_free_total - 1'b1;
                            r_head <= (r_free_total == CountW'(1)) ? CountW'(MaxSlots)
                                : {1'b0, r_link_rd};
                            r_free_total <= r_free_total - 1'b1;
                        end
                    end
                    REQ_RELEASE: begin
                        if (w_rel_ok) begin
                            if (r_free_rd) begin
                                o_rsp.status <= ST_ALREADY_FREE;
                            end else begin
                                o_rsp.ok <= 1'b1;
                                o_rsp.status <= ST_DONE;
                                o_rsp.free_count <= r_free_total + 1'b1;
                                r_head <= {1'b0, w_rel_idx};
                                r_free_total <= r_free_total + 1'b1;
                            end
                        end
                    end
                    REQ_CLEAR: begin
                        o_rsp.ok <= 1'b1;
                        o_rsp.status <= ST_DONE;
                        o_rsp.free_count <= r_clr_n;
                        r_slot_total <= r_clr_n;
                        r_free_total <= r_clr_n;
                        r_head <= (r_clr_n == '0) ? CountW'(MaxSlots) : r_clr_n - 1'b1;
                        r_clr_n <= '1;
                    end
                    default: ;
                endcase
            end
        end
    end

endmodule

@@ test/fbpa_tb_pkg.sv @@
`timescale 1ns / 100ps
// Small shared helpers for the allocator testbench: nothing but a request builder.
package fbpa_tb_pkg;
    import fbpa_pkg::*;

    function automatic t_req make_req(logic [1:0] kind, logic [31:0] cnt, logic [31:0] bytes,
                                      logic [31:0] adr);
        t_req r;
        r.req_type = kind;
        r.num_elems = cnt;
        r.elem_bytes = bytes;
        r.addr = adr;
        return r;
    endfunction
endpackage

@@ test/fbpa_checker.sv @@
`timescale 1ns / 100ps
// Checker for the allocator: predicts each result from observed transactions and compares.
module fbpa_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    input  logic            i_req_ready,
    input  fbpa_pkg::t_req  i_req_data,
    input  logic            i_rsp_valid,
    input  logic            i_rsp_ready,
    input  fbpa_pkg::t_rsp  i_rsp_data,
    input  logic            i_cfg_valid,
    input  logic            i_cfg_ready,
    input  fbpa_pkg::t_cfg  i_cfg_data,
    output int              o_errors,
    output int              o_pending
);
    import fbpa_pkg::*;

    // Shadow copy of the configuration and the free list.
    logic [31:0] base_q;
    logic [20:0] bytes_q;
    logic [16:0] stride_q;
    logic [10:0] link_q [MaxSlots];
    logic        free_q [MaxSlots];
    logic [10:0] head_q;
    logic [10:0] nfree_q;
    logic [10:0] nslots_q;
    t_rsp        expected_rsp [$];

    assign o_pending = expected_rsp.size();

    // Computes the result of one request and updates the shadow free list.
    function automatic t_rsp predict_alloc(t_req r);
        t_rsp o;
        logic [63:0] sz, prod, rnd, hdr, delta, idx, n;
        o = '0;
        sz = 64'(stride_q) + Align;
        o.status = ST_BAD_ADDR;
        case (r.req_type)
            REQ_RESERVE: begin
                prod = 64'(r.num_elems) * 64'(r.elem_bytes);
                rnd = ((prod + Align - 1) / Align) * Align;
                if (r.num_elems == 0 || r.elem_bytes == 0) begin
                    o.status = ST_BAD_SIZE;
                end else if (nfree_q == 0 || head_q >= MaxSlots) begin
                    o.status = ST_EMPTY;
                end else if (prod > stride_q || rnd > stride_q) begin
                    o.status = ST_BAD_SIZE;
                end else begin
                    o.status = ST_DONE;
                    o.data_addr = 32'(64'(base_q) + 64'(head_q) * sz + Align);
                    free_q[head_q] = 1'b0;
                    head_q = link_q[head_q];
                    nfree_q--;
                end
            end
            REQ_RELEASE: begin
                o.status = ST_BAD_ADDR;
                if (r.addr >= Align) begin
                    hdr = 64'(r.addr) - Align;
                    if (hdr >= base_q) begin
                        delta = hdr - base_q;
                        idx = delta / sz;
                        if (delta < bytes_q && delta % sz == 0 && idx < nslots_q) begin
                            if (free_q[idx]) begin
                                o.status = ST_ALREADY_FREE;
                            end else begin
                                o.status = ST_DONE;
                                link_q[idx] = head_q;
                                free_q[idx] = 1'b1;
                                head_q = 11'(idx);
                                nfree_q++;
                            end
                        end
                    end
                end
            end
            REQ_CLEAR: begin
                n = 0;
                if (bytes_q != 0 && stride_q != 0) begin
                    n = 64'(bytes_q) / sz;
                    if (n > MaxSlots) n = MaxSlots;
                end
                head_q = 11'(MaxSlots);
                for (int i = 0; i < MaxSlots; i++) begin
                    free_q[i] = 1'b0;
                    if (i < n) begin
                        link_q[i] = head_q;
                        free_q[i] = 1'b1;
                        head_q = 11'(i);
                    end
                end
                nslots_q = 11'(n);
                nfree_q = 11'(n);
                o.status = ST_DONE;
            end
            default: o.status = ST_BAD_ADDR;
        endcase
        o.ok = (o.status == ST_DONE);
        o.free_count = nfree_q;
        return o;
    endfunction

    // Watches all three channels at each rising edge.
    always @(posedge i_clk) begin
        t_rsp want;
        int   nerr;
        nerr = 0;
        if (!i_rst_n) begin
            base_q = '0;
            bytes_q = '0;
            stride_q = '0;
            head_q = 11'(MaxSlots);
            nfree_q = '0;
            nslots_q = '0;
            o_errors <= 0;
            for (int i = 0; i < MaxSlots; i++) begin
                free_q[i] = 1'b0;
                link_q[i] = '0;
            end
            expected_rsp.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_data.index)
                    CFG_POOL_BASE: base_q = i_cfg_data.data;
                    CFG_POOL_BYTES: bytes_q = i_cfg_data.data[20:0];
                    CFG_SLOT_STRIDE: stride_q = i_cfg_data.data[16:0];
                    default: ;
                endcase
            end
            if (i_req_valid && i_req_ready) expected_rsp.push_back(predict_alloc(i_req_data));
            if (i_rsp_valid && i_rsp_ready) begin
                if (expected_rsp.size() == 0) begin
                    $error("result transaction with nothing expected");
                    nerr++;
                end else begin
                    want = expected_rsp.pop_front();
                    if (want.ok !== i_rsp_data.ok) begin
                        $error("ok: expected %0d, actual %0d", want.ok, i_rsp_data.ok);
                        nerr++;
                    end
                    if (want.status !== i_rsp_data.status) begin
                        $error("status: expected %0d, actual %0d", want.status,
                               i_rsp_data.status);
                        nerr++;
                    end
                    if (want.data_addr !== i_rsp_data.data_addr) begin
                        $error("data_addr: expected %h, actual %h", want.data_addr,
                               i_rsp_data.data_addr);
                        nerr++;
                    end
                    if (want.free_count !== i_rsp_data.free_count) begin
                        $error("free_count: expected %0d, actual %0d", want.free_count,
                               i_rsp_data.free_count);
                        nerr++;
                    end
                end
            end
            o_errors <= o_errors + nerr;
        end
    end
endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps
// Testbench top: clock, reset, stimulus and verdict for the block pool allocator.
module tb;
    import fbpa_pkg::*;
    import fbpa_tb_pkg::*;

    logic i_clk;
    logic i_rst_n;
    int   errors;
    int   pending;
    int   cycles = 0;
    int   stall_mode = 0;

    fbpa_req_if req_ch();
    fbpa_rsp_if rsp_ch();
    fbpa_cfg_if cfg_ch();

    fixed_block_pool_allocator u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch.sink),
        .o_rsp  (rsp_ch.source),
        .i_cfg  (cfg_ch.sink)
    );

    fbpa_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(req_ch.valid),
        .i_req_ready(req_ch.ready),
        .i_req_data (req_ch.data),
        .i_rsp_valid(rsp_ch.valid),
        .i_rsp_ready(rsp_ch.ready),
        .i_rsp_data (rsp_ch.data),
        .i_cfg_valid(cfg_ch.valid),
        .i_cfg_ready(cfg_ch.ready),
        .i_cfg_data (cfg_ch.data),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    // Clock with a 10 ns period.
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Cycle limit: several times the cost of ~700 items that each run a full
    // clear sweep under long gaps and stalls.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 4000000) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Receiver stalls follow a pattern that changes mode now and then.
    always @(posedge i_clk) begin
        if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: rsp_ch.ready <= 1'b1;
            1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            2: rsp_ch.ready <= ($urandom_range(0, 1) != 0);
            default: rsp_ch.ready <= ($urandom_range(0, 9) == 0);
        endcase
    end

    // Random gap between bursts of requests; valid drops only during a gap, a register write or the drain.
    int burst_left;
    task automatic pace();
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 2) != 0) begin
                req_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 40)) @(posedge i_clk);
            end
        end
        burst_left--;
    endtask

    // Sends one request and waits for its acceptance.
    task automatic send_req(t_req r);
        pace();
        req_ch.valid <= 1'b1;
        req_ch.data <= r;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    // Writes one register, waiting until every result is back first.
    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= '{index: idx, data: val};
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_pool(logic [31:0] base, logic [31:0] bytes, logic [31:0] stride);
        write_reg(CFG_POOL_BASE, base);
        write_reg(CFG_POOL_BYTES, bytes);
        write_reg(CFG_SLOT_STRIDE, stride);
    endtask

    // Current geometry as the stimulus sees it.
    logic [31:0] g_base;
    logic [31:0] g_bytes;
    logic [31:0] g_stride;
    logic [31:0] handed [$];

    function automatic logic [31:0] slot_addr(int i);
        return g_base + i * (g_stride + Align) + Align;
    endfunction

    // One random request: mostly well formed reserves and releases.
    task automatic random_req();
        int pick;
        int k;
        logic [31:0] a;
        logic [31:0] c;
        pick = $urandom_range(0, 99);
        if (pick < 42) begin
            c = $urandom_range(1, 4);
            send_req(make_req(REQ_RESERVE, c, $urandom_range(1, g_stride / c + 1), 0));
        end else if (pick < 47) begin
            send_req(make_req(REQ_RESERVE, $urandom, $urandom, 0));
        end else if (pick < 80 && handed.size() != 0) begin
            k = $urandom_range(0, handed.size() - 1);
            a = handed[k];
            handed.delete(k);
            send_req(make_req(REQ_RELEASE, $urandom, $urandom, a));
        end else if (pick < 88) begin
            a = slot_addr($urandom_range(0, 40));
            if ($urandom_range(0, 1)) a = a + $urandom_range(1, 31);
            send_req(make_req(REQ_RELEASE, 0, 0, a));
        end else if (pick < 93) begin
            send_req(make_req(REQ_RELEASE, $urandom, $urandom, $urandom));
        end else if (pick < 97) begin
            send_req(make_req(2'd3, $urandom, $urandom, $urandom));
        end else begin
            send_req(make_req(REQ_CLEAR, $urandom, $urandom, $urandom));
            handed.delete();
        end
    endtask

    // Collects payload addresses of granted reserves so releases can reuse them.
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready && rsp_ch.data.ok
            && rsp_ch.data.data_addr != 0) handed.push_back(rsp_ch.data.data_addr);
    end

    // Stimulus: directed corners, then random phases over several geometries.
    initial begin
        i_rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        burst_left = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Before any clear: empty pool, zero size, null release, unknown request, then a clear with no pool set.
        send_req(make_req(REQ_RESERVE, 1, 1, 0));
        send_req(make_req(REQ_RESERVE, 0, 5, 0));
        send_req(make_req(REQ_RELEASE, 0, 0, 0));
        send_req(make_req(2'd3, '1, '1, '1));
        send_req(make_req(REQ_CLEAR, 0, 0, 0));

        // Small pool of four slots with stride 32.
        g_base = 32'h0000_1000; g_bytes = 4 * 48 + 8; g_stride = 32;
        set_pool(g_base, g_bytes, g_stride);
        send_req(make_req(REQ_CLEAR, 0, 0, 0));
        send_req(make_req(REQ_RESERVE, 0, 1, 0));
        send_req(make_req(REQ_RESERVE, 1, 0, 0));
        send_req(make_req(REQ_RESERVE, 33, 1, 0));
        send_req(make_req(REQ_RESERVE, '1, '1, 0));
        send_req(make_req(REQ_RESERVE, 32, 1, 0));
        send_req(make_req(REQ_RESERVE, 1, 1, 0));
        send_req(make_req(REQ_RESERVE, 4, 4, 0));
        send_req(make_req(REQ_RESERVE, 2, 3, 0));
        send_req(make_req(REQ_RESERVE, 1, 1, 0));
        send_req(make_req(REQ_RELEASE, 0, 0, slot_addr(2)));
        send_req(make_req(REQ_RELEASE, 0, 0, slot_addr(2)));
        send_req(make_req(REQ_RELEASE, 0, 0, slot_addr(1) + 16));
        send_req(make_req(REQ_RELEASE, 0, 0, slot_addr(4)));
        send_req(make_req(REQ_RELEASE, 0, 0, 32'd8));
        send_req(make_req(REQ_RELEASE, 0, 0, g_base));
        send_req(make_req(REQ_RELEASE, 0, 0, 32'hFFFF_FFFF));
        handed.delete();

        // Random phases; geometry changes include extremes and capped slot counts.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin g_base = 32'h0000_1000; g_bytes = 4 * 48 + 8; g_stride = 32; end
                1: begin g_base = 32'hFFFF_0000; g_bytes = 1024 * 64; g_stride = 48; end
                2: begin g_base = 0; g_bytes = 20'hFFFFF; g_stride = 16; end
                3: begin g_base = 32'h8000_0000; g_bytes = 1048576; g_stride = 65536; end
                4: begin g_base = 32'h1234_5670; g_bytes = 300; g_stride = 0; end
                5: begin g_base = 32'hFFFF_FFF0; g_bytes = 0; g_stride = 64; end
                6: begin g_base = 32'h0040_0000; g_bytes = 16 * 112; g_stride = 96; end
                default: begin g_base = 32'hFFFF_FF00; g_bytes = 4096; g_stride = 240; end
            endcase
            set_pool(g_base, g_bytes, g_stride);
            handed.delete();
            send_req(make_req(REQ_CLEAR, $urandom, $urandom, $urandom));
            repeat (80) random_req();
        end

        // Drain, then give the verdict.
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

@@ fixed_block_pool_allocator.f @@
src/fbpa_pkg.sv
src/fbpa_if.sv
src/fbpa_ctrl.sv
src/fbpa_dp.sv
src/fixed_block_pool_allocator.sv
test/fbpa_tb_pkg.sv
test/fbpa_checker.sv
test/tb.sv
